### rtl/asd_pkg.sv
// accel stillness detector: shared widths, sample and flag types, back-end states
// and the pair activity function
// no dependencies
package asd_pkg;

    localparam int AXIS_W    = 16;
    localparam int SAMPLE_W  = 3 * AXIS_W;
    localparam int COUNT_W   = 10;
    localparam int SUM_W     = 21;
    localparam int PAIR_W    = AXIS_W + 2;
    localparam int THRESH_W  = 21;

    localparam logic [SUM_W-1:0]    SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1000);

    typedef struct packed {
        logic signed [AXIS_W-1:0] z;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] x;
    } sample_t;

    // per-item decisions taken by the front end
    typedef struct packed {
        logic checked;  // odd count, sum is formed
        logic warm;     // count above three windows
        logic wrap;     // count returns to zero after this item
    } cmd_flags_t;

    localparam int FLAGS_W = $bits(cmd_flags_t);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_ACC,
        BK_DONE
    } back_state_t;

    function automatic logic [AXIS_W:0] axis_absdiff(logic signed [AXIS_W-1:0] a,
                                                     logic signed [AXIS_W-1:0] b);
        logic signed [AXIS_W:0] d;
        d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
        return d[AXIS_W] ? (AXIS_W+1)'(-d) : (AXIS_W+1)'(d);
    endfunction

    function automatic logic [PAIR_W-1:0] pair_activity(sample_t a, sample_t b);
        logic [PAIR_W-1:0] s;
        s = PAIR_W'(axis_absdiff(a.x, b.x))
          + PAIR_W'(axis_absdiff(a.y, b.y))
          + PAIR_W'(axis_absdiff(a.z, b.z));
        return s;
    endfunction

endpackage

### rtl/asd_if.sv
// accel stillness detector: handshake channels for samples, results and the
// threshold write port
// depends on asd_pkg
interface asd_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [asd_pkg::AXIS_W-1:0]  accel_x;
    logic signed [asd_pkg::AXIS_W-1:0]  accel_y;
    logic signed [asd_pkg::AXIS_W-1:0]  accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface asd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          stable;
    logic                          checked;
    logic [asd_pkg::SUM_W-1:0]     activity_sum;

    modport source (output valid, output stable, output checked, output activity_sum,
                    input ready);
    modport sink   (input valid, input stable, input checked, input activity_sum,
                    output ready);
endinterface

interface asd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [asd_pkg::THRESH_W-1:0]  stillness_threshold;

    modport source (output valid, output stillness_threshold, input ready);
    modport sink   (input valid, input stillness_threshold, output ready);
endinterface

### rtl/asd_queue.sv
// accel stillness detector: two-entry command queue between front and back end
// no package dependencies
module asd_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output logic [DW-1:0] head
);

    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/asd_front.sv
// accel stillness detector: front end, takes samples, keeps the count and slot
// and classifies each item; depends on asd_pkg and asd_if
module asd_front #(
    parameter int WINDOW     = 16,
    parameter int COUNT_WRAP = 1000,
    parameter int AW         = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    asd_sample_if.sink         samples,
    input  logic               queue_full,
    output logic               push,
    output asd_pkg::sample_t   push_sample,
    output logic [AW-1:0]      push_slot,
    output asd_pkg::cmd_flags_t push_flags
);

    logic [asd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]               slot_reg, slot_next;
    logic                        wrap;

    assign samples.ready = ~queue_full;
    assign push          = samples.valid & ~queue_full;

    assign push_sample.x = samples.accel_x;
    assign push_sample.y = samples.accel_y;
    assign push_sample.z = samples.accel_z;
    assign push_slot     = slot_reg;

    assign wrap               = (count_reg == asd_pkg::COUNT_W'(COUNT_WRAP - 1));
    assign push_flags.checked = count_reg[0];
    assign push_flags.warm    = (count_reg > asd_pkg::COUNT_W'(3 * WINDOW));
    assign push_flags.wrap    = wrap;

    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (push)
        begin
            if (wrap)
            begin
                count_next = '0;
                slot_next  = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                slot_next  = (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

### rtl/asd_back.sv
// accel stillness detector: back end, sample ring memory, pairwise activity sum
// with a read state and an accumulate state per pair, threshold register and result register
// depends on asd_pkg and asd_if
module asd_back #(
    parameter int WINDOW = 16,
    parameter int AW     = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  asd_pkg::sample_t    cmd_sample,
    input  logic [AW-1:0]       cmd_slot,
    input  asd_pkg::cmd_flags_t cmd_flags,
    output logic                cmd_pop,
    asd_cfg_if.sink             cfg,
    asd_result_if.source        results
);

    localparam int NPAIRS = WINDOW / 2;
    localparam int PW     = (NPAIRS > 1) ? $clog2(NPAIRS) : 1;

    // ring storage, reads registered
    asd_pkg::sample_t ring_mem [WINDOW];
    asd_pkg::sample_t rd_a_reg, rd_b_reg;
    logic             rd_a_ok_reg, rd_b_ok_reg;

    logic [WINDOW-1:0]           slot_valid_reg, slot_valid_next;
    asd_pkg::back_state_t        state_reg, state_next;
    logic [PW-1:0]               pair_reg, pair_next;
    logic [asd_pkg::SUM_W-1:0]   acc_reg, acc_next;
    asd_pkg::cmd_flags_t         flags_reg, flags_next;
    logic [asd_pkg::THRESH_W-1:0] thresh_reg;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_stable_reg, out_stable_next;
    logic                        out_checked_reg, out_checked_next;
    logic [asd_pkg::SUM_W-1:0]   out_sum_reg, out_sum_next;

    logic                        mem_we;
    logic [AW-1:0]               rd_addr_a, rd_addr_b;
    asd_pkg::sample_t            op_a, op_b;
    logic [asd_pkg::SUM_W:0]     acc_wide;

    assign cfg.ready            = 1'b1;
    assign results.valid        = out_valid_reg;
    assign results.stable       = out_stable_reg;
    assign results.checked      = out_checked_reg;
    assign results.activity_sum = out_sum_reg;

    assign rd_addr_a = AW'({pair_reg, 1'b0});
    assign rd_addr_b = AW'({pair_reg, 1'b1});
    assign op_a      = rd_a_ok_reg ? rd_a_reg : '0;
    assign op_b      = rd_b_ok_reg ? rd_b_reg : '0;
    assign acc_wide  = {1'b0, acc_reg}
                     + (asd_pkg::SUM_W + 1)'(asd_pkg::pair_activity(op_a, op_b));

    always_comb
    begin
        state_next       = state_reg;
        pair_next        = pair_reg;
        acc_next         = acc_reg;
        flags_next       = flags_reg;
        slot_valid_next  = slot_valid_reg;
        out_valid_next   = out_valid_reg & ~results.ready;
        out_stable_next  = out_stable_reg;
        out_checked_next = out_checked_reg;
        out_sum_next     = out_sum_reg;
        cmd_pop          = 1'b0;
        mem_we           = 1'b0;

        unique case (state_reg)
            asd_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop                   = 1'b1;
                    mem_we                    = 1'b1;
                    slot_valid_next[cmd_slot] = 1'b1;
                    flags_next                = cmd_flags;
                    pair_next                 = '0;
                    acc_next                  = '0;
                    state_next = cmd_flags.checked ? asd_pkg::BK_READ : asd_pkg::BK_DONE;
                end
            end
            asd_pkg::BK_READ:
            begin
                state_next = asd_pkg::BK_ACC;
            end
            asd_pkg::BK_ACC:
            begin
                // saturating accumulate
                acc_next = acc_wide[asd_pkg::SUM_W] ? asd_pkg::SUM_MAX
                                                    : acc_wide[asd_pkg::SUM_W-1:0];
                if (pair_reg == PW'(NPAIRS - 1))
                begin
                    state_next = asd_pkg::BK_DONE;
                end
                else
                begin
                    pair_next  = pair_reg + 1'b1;
                    state_next = asd_pkg::BK_READ;
                end
            end
            asd_pkg::BK_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_checked_next = flags_reg.checked;
                    out_sum_next     = acc_reg;
                    out_stable_next  = flags_reg.checked & flags_reg.warm
                                     & (asd_pkg::THRESH_W'(acc_reg) < thresh_reg);
                    if (flags_reg.wrap)
                    begin
                        slot_valid_next = '0;
                    end
                    state_next = asd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = asd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= asd_pkg::BK_IDLE;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            thresh_reg     <= asd_pkg::THRESH_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
            begin
                thresh_reg <= cfg.stillness_threshold;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg        <= pair_next;
        acc_reg         <= acc_next;
        flags_reg       <= flags_next;
        out_stable_reg  <= out_stable_next;
        out_checked_reg <= out_checked_next;
        out_sum_reg     <= out_sum_next;
        rd_a_ok_reg     <= slot_valid_reg[rd_addr_a];
        rd_b_ok_reg     <= slot_valid_reg[rd_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[cmd_slot] <= cmd_sample;
        end
        rd_a_reg <= ring_mem[rd_addr_a];
        rd_b_reg <= ring_mem[rd_addr_b];
    end

endmodule

### rtl/accel_stillness_detector.sv
// accel stillness detector top level: front end, command queue and back end
// depends on asd_pkg, asd_if, asd_queue, asd_front and asd_back
//
// one signed 3-axis sample per transfer on samples, one result per sample on
// results. each sample lands in a ring of WINDOW slots at count mod WINDOW;
// after an odd-numbered sample the block sums the absolute per-axis
// differences of slot pairs (0,1), (2,3) and so on, saturating at 21 bits,
// and flags stable once the count is above three windows and the sum is
// below stillness_threshold (reset value 1000, written over cfg by the user
// only while idle; the block does not enforce this). the count returns to
// zero at COUNT_WRAP and the ring then reads as zeros again. in the back end
// an odd-count sample costs one registered ring read and one accumulate per
// slot pair; an even-count sample goes straight to the result stage. the
// front end keeps taking samples into a two-deep queue while the back end
// sums, and the result register lets the next sum run while a result waits
// for its transfer. ring slots never written since reset or the last wrap
// read as zero through per-slot valid flags, so no clearing pass is needed
module accel_stillness_detector #(
    parameter int WINDOW     = 16,
    parameter int COUNT_WRAP = 1000
) (
    input  logic          clk,
    input  logic          rst_n,
    asd_sample_if.sink    samples,
    asd_result_if.source  results,
    asd_cfg_if.sink       cfg
);

    localparam int AW    = $clog2(WINDOW);
    localparam int CMD_W = asd_pkg::SAMPLE_W + AW + asd_pkg::FLAGS_W;

    // front to queue
    logic                 push;
    asd_pkg::sample_t     push_sample;
    logic [AW-1:0]        push_slot;
    asd_pkg::cmd_flags_t  push_flags;
    logic                 queue_full;

    // queue to back
    logic                 queue_not_empty;
    logic                 queue_pop;
    logic [CMD_W-1:0]     queue_head;
    asd_pkg::sample_t     head_sample;
    logic [AW-1:0]        head_slot;
    asd_pkg::cmd_flags_t  head_flags;

    asd_front #(
        .WINDOW     (WINDOW),
        .COUNT_WRAP (COUNT_WRAP),
        .AW         (AW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .queue_full  (queue_full),
        .push        (push),
        .push_sample (push_sample),
        .push_slot   (push_slot),
        .push_flags  (push_flags)
    );

    // command word: sample, ring slot, decisions
    asd_queue #(
        .DW (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_sample, push_slot, push_flags}),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head      (queue_head)
    );

    assign head_sample = asd_pkg::sample_t'(queue_head[CMD_W-1 -: asd_pkg::SAMPLE_W]);
    assign head_slot   = queue_head[asd_pkg::FLAGS_W +: AW];
    assign head_flags  = asd_pkg::cmd_flags_t'(queue_head[asd_pkg::FLAGS_W-1:0]);

    asd_back #(
        .WINDOW (WINDOW),
        .AW     (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_not_empty),
        .cmd_sample (head_sample),
        .cmd_slot   (head_slot),
        .cmd_flags  (head_flags),
        .cmd_pop    (queue_pop),
        .cfg        (cfg),
        .results    (results)
    );

endmodule

### tb/asd_checker.sv
// accel stillness detector checker: watches the sample, result and threshold
// channels, predicts each result and compares it field by field
// depends on asd_pkg and asd_if
module asd_checker
    import asd_pkg::*;
#(
    parameter int WINDOW     = 16,
    parameter int COUNT_WRAP = 1000
) (
    input  logic   clk,
    input  logic   rst_n,
    asd_sample_if  samples,
    asd_result_if  results,
    asd_cfg_if     cfg,
    output int     mismatches,
    output int     outstanding,
    output int     sums_checked,
    output int     stable_seen,
    output int     wraps
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             stable;
        logic             checked;
        logic [SUM_W-1:0] activity_sum;
    } verdict_t;

    sample_t             ring [WINDOW];
    logic [COUNT_W-1:0]  count;
    logic [THRESH_W-1:0] threshold;
    verdict_t            awaited_verdicts [$];
    sample_t             incoming;
    verdict_t            due;
    int                  results_seen;

    function automatic int unsigned axis_gap(logic signed [AXIS_W-1:0] a,
                                             logic signed [AXIS_W-1:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    // store the sample, form the sum on odd counts, then advance and wrap
    function automatic verdict_t judge_sample(sample_t s);
        verdict_t        v;
        longint unsigned total;
        v = '0;
        total = 0;
        ring[int'(count) % WINDOW] = s;
        if (count[0])
        begin
            for (int j = 0; j + 1 < WINDOW; j += 2)
                total += axis_gap(ring[j].x, ring[j+1].x) + axis_gap(ring[j].y, ring[j+1].y)
                       + axis_gap(ring[j].z, ring[j+1].z);
            v.checked = 1'b1;
            v.activity_sum = (total > SUM_MAX) ? SUM_MAX : SUM_W'(total);
            v.stable = (int'(count) > 3 * WINDOW) && (v.activity_sum < threshold);
        end
        count = count + 1'b1;
        if (int'(count) >= COUNT_WRAP)
        begin
            count = '0;
            foreach (ring[i])
                ring[i] = '0;
            wraps++;
        end
        return v;
    endfunction

    task automatic flag_fault(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%t %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (ring[i])
                ring[i] = '0;
            count = '0;
            threshold = THRESH_RESET;
            awaited_verdicts.delete();
            mismatches = 0;
            outstanding = 0;
            sums_checked = 0;
            stable_seen = 0;
            wraps = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                threshold = cfg.stillness_threshold;
            if (samples.valid && samples.ready)
            begin
                incoming.x = samples.accel_x;
                incoming.y = samples.accel_y;
                incoming.z = samples.accel_z;
                awaited_verdicts.push_back(judge_sample(incoming));
            end
            if (results.valid && results.ready)
            begin
                results_seen++;
                if (results.checked)
                    sums_checked++;
                if (results.stable)
                    stable_seen++;
                if (awaited_verdicts.size() == 0)
                    flag_fault($sformatf("result %0d arrived with no sample awaiting it",
                                         results_seen));
                else
                begin
                    due = awaited_verdicts.pop_front();
                    if (results.stable !== due.stable || results.checked !== due.checked
                        || results.activity_sum !== due.activity_sum)
                        flag_fault($sformatf(
                            "result %0d: wanted stable=%0b checked=%0b sum=%0d, got %0b %0b %0d",
                            results_seen, due.stable, due.checked, due.activity_sum,
                            results.stable, results.checked, results.activity_sum));
                end
            end
            outstanding = awaited_verdicts.size();
        end
    end

endmodule

### tb/tb_accel_stillness_detector.sv
// accel stillness detector testbench top: clock, reset, sample and threshold
// stimulus, result back-pressure and the verdict
// depends on asd_pkg, asd_if, accel_stillness_detector and asd_checker
module tb_accel_stillness_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import asd_pkg::*;

    localparam int WINDOW        = 16;
    localparam int COUNT_WRAP    = 1000;
    // ample slack beyond the back-end work of an odd-count sample
    localparam int SETTLE_CYCLES = 40;

    localparam logic [AXIS_W-1:0] AXIS_MAX = 16'h7FFF;
    localparam logic [AXIS_W-1:0] AXIS_MIN = 16'h8000;

    logic clk;
    logic rst_n;

    // handshake seen at the last rising edge, read back at the falling edge
    logic sample_taken = 1'b0;
    logic cfg_taken    = 1'b0;

    int tx_idle_pct;
    int rx_idle_pct;
    int samples_sent;
    int settings_used;

    int mismatches;
    int outstanding;
    int sums_checked;
    int stable_seen;
    int wraps;

    asd_sample_if sample_ch ();
    asd_result_if result_ch ();
    asd_cfg_if    cfg_ch ();

    accel_stillness_detector #(
        .WINDOW     (WINDOW),
        .COUNT_WRAP (COUNT_WRAP)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    asd_checker #(
        .WINDOW     (WINDOW),
        .COUNT_WRAP (COUNT_WRAP)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (sample_ch),
        .results      (result_ch),
        .cfg          (cfg_ch),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .sums_checked (sums_checked),
        .stable_seen  (stable_seen),
        .wraps        (wraps)
    );

    // 2 ns period
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        sample_taken <= sample_ch.valid && sample_ch.ready;
        cfg_taken    <= cfg_ch.valid && cfg_ch.ready;
    end

    // result back-pressure, one fresh draw per cycle
    always @(negedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // small symmetric noise around a quiet base value
    function automatic int jitter(int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    function automatic logic [AXIS_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return AXIS_MAX;
            1:       return AXIS_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // one sample transfer, entered and left at a falling edge
    task automatic send_sample(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                               input logic [AXIS_W-1:0] z);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= x;
        sample_ch.accel_y <= y;
        sample_ch.accel_z <= z;
        do
            @(negedge clk);
        while (!sample_taken);
        samples_sent++;
    endtask

    // hold the sender until every awaited result has come, then let the block settle
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // threshold writes only happen with the block idle
    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        wait_drained();
        cfg_ch.valid               <= 1'b1;
        cfg_ch.stillness_threshold <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // random bursts: mostly quiet runs that can pass the check, some full-range
    // noise and some runs of extreme values
    task automatic run_phase(input int n_items, input int halt_at);
        int sent;
        int len;
        int kind;
        int amp;
        int bx;
        int by;
        int bz;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(4, 40);
            case ($urandom_range(0, 3))
                0:       amp = 0;
                1:       amp = 2;
                2:       amp = 10;
                default: amp = 40;
            endcase
            bx = int'($urandom_range(0, 64000)) - 32000;
            by = int'($urandom_range(0, 64000)) - 32000;
            bz = int'($urandom_range(0, 64000)) - 32000;
            for (int k = 0; k < len && sent < n_items; k++)
            begin
                if (sent == halt_at)
                    wait_drained();
                if (kind < 7)
                    send_sample(AXIS_W'(bx + jitter(amp)), AXIS_W'(by + jitter(amp)),
                                AXIS_W'(bz + jitter(amp)));
                else if (kind < 9)
                    send_sample(AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
                else
                    send_sample(pick_extreme(), pick_extreme(), pick_extreme());
                sent++;
            end
        end
    endtask

    initial
    begin
        // every input known from time zero
        rst_n                      = 1'b0;
        sample_ch.valid            = 1'b0;
        sample_ch.accel_x          = '0;
        sample_ch.accel_y          = '0;
        sample_ch.accel_z          = '0;
        result_ch.ready            = 1'b0;
        cfg_ch.valid               = 1'b0;
        cfg_ch.stillness_threshold = '0;
        tx_idle_pct                = 14;
        rx_idle_pct                = 58;
        samples_sent               = 0;
        settings_used              = 1;

        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part under the reset threshold: alternating full-scale
        // samples drive every pair to its largest gap, so the sum peaks on
        // the sixteenth sample; even counts give no check
        for (int i = 0; i < 16; i++)
            if (i % 2 == 0)
                send_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX);
            else
                send_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN);
        send_sample(AXIS_MAX, AXIS_MIN, '0);
        send_sample(AXIS_MIN, AXIS_MAX, '1);
        send_sample(16'h5555, 16'hAAAA, 16'h0001);
        send_sample(16'hAAAA, 16'h5555, 16'h3039);

        // zero threshold: nothing can ever be stable
        write_threshold('0);
        run_phase(280, -1);

        // sender now the slow side; largest threshold passes every warm check
        tx_idle_pct = 58;
        rx_idle_pct = 14;
        write_threshold(SUM_MAX);
        run_phase(300, 150);

        write_threshold(THRESH_W'($urandom));
        run_phase(300, -1);

        // no idling at all; a threshold near the quiet sums; the count wraps here
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_threshold(THRESH_W'(1500));
        run_phase(300, -1);

        wait_drained();
        $display("%0d samples over %0d threshold settings, %0d sums compared",
                 samples_sent, settings_used, sums_checked);
        $display("%0d results flagged stable, count wrapped %0d time(s)", stable_seen, wraps);
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("timeout with %0d results still awaited", outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
